@@ src/lbg_pkg.sv @@
// Shared types and constants for the light box gather and nearest block.
// No dependencies; used by every module under src.
`default_nettype none
package lbg_pkg;

   localparam int MAX_LIGHTS_DEF = 64;
   localparam int COORD_BITS_DEF = 24;
   localparam int CUT_BITS       = 23;
   localparam int COUNT_BITS     = 7;
   localparam int OUT_IDX_BITS   = 6;
   localparam int RESULT_CAP     = 64;

   // nearest search bound: 999999 units in Q20.4, squared
   localparam logic [63:0] NEAR_BOUND_Q = 64'd15999984;
   localparam logic [63:0] BOUND_SQ     = NEAR_BOUND_Q * NEAR_BOUND_Q;

   typedef enum logic [1:0] {
      OP_WR_BOX  = 2'd0,
      OP_WR_ORG  = 2'd1,
      OP_GATHER  = 2'd2,
      OP_NEAREST = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // status from the evaluation unit back to the sequencer
   typedef struct packed {
      logic s1_valid;
      logic s1_overlap;
      logic found;
   } eval_status_type;

endpackage
`default_nettype wire

@@ src/lbg_cell.sv @@
// One light record cell of the rotating light chain.
// Depends on lbg_pkg.
`default_nettype none
module lbg_cell
   import lbg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IDX        = 0
) (
   input  wire logic                          clock,
   input  wire logic                          shift_en,
   input  wire logic                          wr_box_en,
   input  wire logic                          wr_org_en,
   input  wire logic [OUT_IDX_BITS-1:0]       wr_index,
   input  wire logic [9*COORD_BITS+CUT_BITS:0] wr_rec,
   input  wire logic [9*COORD_BITS+CUT_BITS:0] next_rec,
   output logic      [9*COORD_BITS+CUT_BITS:0] rec
);

   localparam int REC_W = 9*COORD_BITS + CUT_BITS + 1;
   localparam int BOX_W = 6*COORD_BITS;
   localparam int ORG_W = REC_W - BOX_W;

   logic [REC_W-1:0] rec_ff, rec_in;
   logic             sel;

   assign sel = (32'(wr_index) == IDX);

   always_comb begin
      rec_in = rec_ff;
      if (shift_en) begin
         rec_in = next_rec;
      end else begin
         if (wr_box_en && sel) rec_in[REC_W-1 -: BOX_W] = wr_rec[REC_W-1 -: BOX_W];
         if (wr_org_en && sel) rec_in[ORG_W-1:0] = wr_rec[ORG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule
`default_nettype wire

@@ src/lbg_eval.sv @@
// Evaluation unit: overlap test, squared distances and running nearest.
// Depends on lbg_pkg; fed from the head cell of the light chain.
`default_nettype none
module lbg_eval
   import lbg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IW         = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           clear,
   input  wire logic                           adv,
   input  wire logic                           ld_valid,
   input  wire logic [IW-1:0]                  ld_idx,
   input  wire logic [9*COORD_BITS+CUT_BITS:0] rec,
   input  wire logic [COORD_BITS-1:0]          q_lo_x,
   input  wire logic [COORD_BITS-1:0]          q_lo_y,
   input  wire logic [COORD_BITS-1:0]          q_lo_z,
   input  wire logic [COORD_BITS-1:0]          q_hi_x,
   input  wire logic [COORD_BITS-1:0]          q_hi_y,
   input  wire logic [COORD_BITS-1:0]          q_hi_z,
   output eval_status_type                     status,
   output logic [IW-1:0]                       s1_idx,
   output logic [IW-1:0]                       best_idx
);

   localparam int CB    = COORD_BITS;
   localparam int REC_W = 9*CB + CUT_BITS + 1;

   logic [CB-1:0] l_lox, l_loy, l_loz, l_hix, l_hiy, l_hiz, l_ox, l_oy, l_oz;
   logic [CUT_BITS-1:0] l_cut;
   logic                l_dir, ovl;

   assign l_lox = rec[REC_W-1      -: CB];
   assign l_loy = rec[REC_W-1-1*CB -: CB];
   assign l_loz = rec[REC_W-1-2*CB -: CB];
   assign l_hix = rec[REC_W-1-3*CB -: CB];
   assign l_hiy = rec[REC_W-1-4*CB -: CB];
   assign l_hiz = rec[REC_W-1-5*CB -: CB];
   assign l_ox  = rec[REC_W-1-6*CB -: CB];
   assign l_oy  = rec[REC_W-1-7*CB -: CB];
   assign l_oz  = rec[REC_W-1-8*CB -: CB];
   assign l_cut = rec[CUT_BITS:1];
   assign l_dir = rec[0];

   function automatic logic [63:0] sq_sat(input logic [CB-1:0] a, input logic [CB-1:0] b);
      logic signed [CB:0] d;
      logic [CB:0]        m;
      logic [63:0]        ax;
      logic [31:0]        r;
      d  = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
      m  = d[CB] ? (CB+1)'(-d) : d;
      ax = 64'(m);
      r  = ax[31:0];
      if (ax > 64'h0000_0000_FFFF_FFFF) sq_sat = '1;
      else sq_sat = 64'(r) * 64'(r);
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      add_sat = s[64] ? '1 : s[63:0];
   endfunction

   assign ovl = !($signed(l_lox) > $signed(q_hi_x) || $signed(l_loy) > $signed(q_hi_y) ||
                  $signed(l_loz) > $signed(q_hi_z) || $signed(l_hix) < $signed(q_lo_x) ||
                  $signed(l_hiy) < $signed(q_lo_y) || $signed(l_hiz) < $signed(q_lo_z));

   // stage 1: overlap and per-axis squares
   logic                s1_valid_ff, s1_ovl_ff, s1_dir_ff;
   logic [IW-1:0]       s1_idx_ff;
   logic [63:0]         sqx_ff, sqy_ff, sqz_ff;
   logic [2*CUT_BITS-1:0] s1_c2_ff;
   // stage 2: summed distance
   logic                s2_valid_ff, s2_dir_ff;
   logic [IW-1:0]       s2_idx_ff;
   logic [63:0]         s2_sum_ff;
   logic [2*CUT_BITS-1:0] s2_c2_ff;
   // running best
   logic [63:0]         best_ff;
   logic                found_ff;
   logic [IW-1:0]       bidx_ff;
   logic                take;

   assign take = s2_valid_ff && !s2_dir_ff && (s2_sum_ff < best_ff) &&
                 (s2_sum_ff <= 64'(s2_c2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else if (clear) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= ld_valid;
         s2_valid_ff <= s1_valid_ff;
         if (take) found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         best_ff <= BOUND_SQ;
         bidx_ff <= '0;
      end else if (adv) begin
         s1_ovl_ff <= ovl;
         s1_dir_ff <= l_dir;
         s1_idx_ff <= ld_idx;
         sqx_ff    <= sq_sat(q_lo_x, l_ox);
         sqy_ff    <= sq_sat(q_lo_y, l_oy);
         sqz_ff    <= sq_sat(q_lo_z, l_oz);
         s1_c2_ff  <= (2*CUT_BITS)'(l_cut) * (2*CUT_BITS)'(l_cut);
         s2_dir_ff <= s1_dir_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_c2_ff  <= s1_c2_ff;
         s2_sum_ff <= add_sat(add_sat(sqx_ff, sqy_ff), sqz_ff);
         if (take) begin
            best_ff <= s2_sum_ff;
            bidx_ff <= s2_idx_ff;
         end
      end
   end

   assign status.s1_valid   = s1_valid_ff;
   assign status.s1_overlap = s1_ovl_ff;
   assign status.found      = found_ff;
   assign s1_idx            = s1_idx_ff;
   assign best_idx          = bidx_ff;

endmodule
`default_nettype wire

@@ src/light_box_gather_and_nearest.sv @@
// Top level of the light box gather and nearest block.
// Depends on lbg_pkg, lbg_cell and lbg_eval.
`default_nettype none
// The light table lives in a ring of MAX_LIGHTS cells, one light per cell.
// Write beats (ops 0 and 1) land in their cell and give no result. A query
// beat rotates the ring through MAX_LIGHTS shifts so that every light passes
// the head cell in index order, then the walk drains the evaluation pipeline
// and the done state loads the final beat; stalls on the result side hold
// the query up. The ring is back in its original order when the walk ends.
// Gather results go out as they are found, each one held back until the next
// hit or the end of the walk so that last can be set; the walk pauses while
// the output register is full and stalled. A nearest query gives a single
// beat. The table has no reset: reading an entry never written is undefined.
// The user must write light_count through csr_we/csr_wdata only while the
// block idles; the block itself does not enforce this.
module light_box_gather_and_nearest
   import lbg_pkg::*;
#(
   parameter int MAX_LIGHTS = MAX_LIGHTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [COUNT_BITS-1:0]   csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_op,
   input  wire logic [OUT_IDX_BITS-1:0] req_light_index,
   input  wire logic [COORD_BITS-1:0]   req_lo_x,
   input  wire logic [COORD_BITS-1:0]   req_lo_y,
   input  wire logic [COORD_BITS-1:0]   req_lo_z,
   input  wire logic [COORD_BITS-1:0]   req_hi_x,
   input  wire logic [COORD_BITS-1:0]   req_hi_y,
   input  wire logic [COORD_BITS-1:0]   req_hi_z,
   input  wire logic [CUT_BITS-1:0]     req_cutoff_dist,
   input  wire logic                    req_is_directional,
   input  wire logic [COUNT_BITS-1:0]   req_max_count,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_hit,
   output logic [OUT_IDX_BITS-1:0]      rsp_result_index,
   output logic                         rsp_last
);

   localparam int REC_W = 9*COORD_BITS + CUT_BITS + 1;
   localparam int IW    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int SW    = $clog2(MAX_LIGHTS + 2);

   // ---------------- control state ----------------
   state_type               state_ff, state_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [COUNT_BITS-1:0]   count_ff;
   logic                    gather_ff;
   logic [COUNT_BITS-1:0]   cap_ff, cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [IW-1:0]           pend_idx_ff, pend_idx_in;
   logic [COORD_BITS-1:0]   q_lo_x_ff, q_lo_y_ff, q_lo_z_ff;
   logic [COORD_BITS-1:0]   q_hi_x_ff, q_hi_y_ff, q_hi_z_ff;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [OUT_IDX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept, query_acc, out_free, adv, emit_g, fin, shift_en;
   logic [SW-1:0]           n_lim;
   eval_status_type         ev;
   logic [IW-1:0]           s1_idx, best_idx;
   logic [REC_W-1:0]        wr_rec;
   logic [REC_W-1:0]        ring [MAX_LIGHTS];

   assign accept    = req_valid && !req_stall;
   assign query_acc = accept && (req_op == OP_GATHER || req_op == OP_NEAREST);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign n_lim     = (32'(count_ff) > MAX_LIGHTS) ? SW'(MAX_LIGHTS) : SW'(count_ff);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (query_acc) state_in = ST_WALK;
         ST_WALK: if (out_free && 32'(step_ff) == MAX_LIGHTS + 1) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer ----------------
   always_comb begin
      req_stall = 1'b1;
      adv       = 1'b0;
      fin       = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_WALK: adv = out_free;
         ST_DONE: fin = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign shift_en = adv && (32'(step_ff) < MAX_LIGHTS);
   assign step_in  = query_acc ? '0 : (adv ? step_ff + SW'(1) : step_ff);

   // gather: hold the newest hit back until we know whether it is the last
   assign emit_g = adv && gather_ff && ev.s1_valid && ev.s1_overlap &&
                   (cnt_ff < cap_ff) && pend_ff;

   always_comb begin
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      if (query_acc) begin
         cnt_in  = '0;
         pend_in = 1'b0;
      end else if (adv && gather_ff && ev.s1_valid && ev.s1_overlap && cnt_ff < cap_ff) begin
         cnt_in      = cnt_ff + COUNT_BITS'(1);
         pend_in     = 1'b1;
         pend_idx_in = s1_idx;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit_g || fin;
         if (emit_g) begin
            rsp_hit_in   = 1'b1;
            rsp_index_in = OUT_IDX_BITS'(pend_idx_ff);
            rsp_last_in  = 1'b0;
         end else if (fin) begin
            rsp_last_in = 1'b1;
            if (gather_ff) begin
               rsp_hit_in   = pend_ff;
               rsp_index_in = pend_ff ? OUT_IDX_BITS'(pend_idx_ff) : '0;
            end else begin
               rsp_hit_in   = ev.found;
               rsp_index_in = ev.found ? OUT_IDX_BITS'(best_idx) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         if (csr_we) count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      pend_idx_ff  <= pend_idx_in;
      if (query_acc) begin
         gather_ff <= (req_op == OP_GATHER);
         cap_ff    <= (32'(req_max_count) > RESULT_CAP) ? COUNT_BITS'(RESULT_CAP)
                                                        : req_max_count;
         q_lo_x_ff <= req_lo_x;
         q_lo_y_ff <= req_lo_y;
         q_lo_z_ff <= req_lo_z;
         q_hi_x_ff <= req_hi_x;
         q_hi_y_ff <= req_hi_y;
         q_hi_z_ff <= req_hi_z;
      end
   end

   // ---------------- light ring ----------------
   assign wr_rec = {req_lo_x, req_lo_y, req_lo_z, req_hi_x, req_hi_y, req_hi_z,
                    req_lo_x, req_lo_y, req_lo_z, req_cutoff_dist, req_is_directional};

   for (genvar g = 0; g < MAX_LIGHTS; g++) begin : g_ring
      lbg_cell #(
         .COORD_BITS (COORD_BITS),
         .IDX        (g)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .wr_box_en (accept && req_op == OP_WR_BOX),
         .wr_org_en (accept && req_op == OP_WR_ORG),
         .wr_index  (req_light_index),
         .wr_rec    (wr_rec),
         .next_rec  (ring[(g + 1) % MAX_LIGHTS]),
         .rec       (ring[g])
      );
   end

   lbg_eval #(
      .COORD_BITS (COORD_BITS),
      .IW         (IW)
   ) u_eval (
      .clock    (clock),
      .reset    (reset),
      .clear    (query_acc),
      .adv      (adv),
      .ld_valid (shift_en && (step_ff < n_lim)),
      .ld_idx   (IW'(step_ff)),
      .rec      (ring[0]),
      .q_lo_x   (q_lo_x_ff),
      .q_lo_y   (q_lo_y_ff),
      .q_lo_z   (q_lo_z_ff),
      .q_hi_x   (q_hi_x_ff),
      .q_hi_y   (q_hi_y_ff),
      .q_hi_z   (q_hi_z_ff),
      .status   (ev),
      .s1_idx   (s1_idx),
      .best_idx (best_idx)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------- assertions ----------------
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> 32'(step_ff) <= MAX_LIGHTS + 1)
      else $error("walk step out of range");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> cnt_ff <= cap_ff)
      else $error("gather count passed its cap");

   a_final_beat: assert property (@(posedge clock) disable iff (reset)
      fin |=> rsp_valid_ff && rsp_last_ff && state_ff == ST_IDLE)
      else $error("query end did not load a last beat");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      query_acc |=> req_stall)
      else $error("query accepted while walking");

endmodule
`default_nettype wire

@@ test/tb_light_box_gather_and_nearest.sv @@
// Testbench for light_box_gather_and_nearest: directed table, then random
// writes and queries checked beat by beat against an in-bench light table.
// Depends on lbg_pkg and the block under src.
`timescale 1ns / 1ps
module tb_light_box_gather_and_nearest
   import lbg_pkg::*;
;

   typedef logic signed [23:0] coord_type;

   typedef struct {
      op_type      op;
      logic [5:0]  light_index;
      coord_type   lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
      logic [22:0] cutoff_dist;
      logic        is_directional;
      logic [6:0]  max_count;
   } light_beat_type;

   typedef struct {
      logic       hit;
      logic [5:0] result_index;
      logic       last;
   } answer_type;

   // directed rows: a row either writes light_count or sends one beat; a beat
   // with typed_answer carries its single answer typed in here
   typedef struct {
      bit             is_csr;
      logic [6:0]     csr_value;
      light_beat_type beat;
      bit             typed_answer;
      logic           typed_hit;
      logic [5:0]     typed_index;
   } table_row_type;

   logic clock = 0;
   logic reset;
   logic csr_we;
   logic [6:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_op;
   logic [5:0] req_light_index;
   logic [23:0] req_lo_x, req_lo_y, req_lo_z, req_hi_x, req_hi_y, req_hi_z;
   logic [22:0] req_cutoff_dist;
   logic req_is_directional;
   logic [6:0] req_max_count;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic [5:0] rsp_result_index;
   logic rsp_last;

   always #5 clock = ~clock;

   light_box_gather_and_nearest dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_light_index(req_light_index),
      .req_lo_x(req_lo_x), .req_lo_y(req_lo_y), .req_lo_z(req_lo_z),
      .req_hi_x(req_hi_x), .req_hi_y(req_hi_y), .req_hi_z(req_hi_z),
      .req_cutoff_dist(req_cutoff_dist), .req_is_directional(req_is_directional),
      .req_max_count(req_max_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_result_index(rsp_result_index), .rsp_last(rsp_last)
   );

   // bench copy of the light table and register
   coord_type   tbl_lo_x[64], tbl_lo_y[64], tbl_lo_z[64];
   coord_type   tbl_hi_x[64], tbl_hi_y[64], tbl_hi_z[64];
   coord_type   tbl_org_x[64], tbl_org_y[64], tbl_org_z[64];
   logic [22:0] tbl_cutoff[64];
   logic        tbl_directional[64];
   logic [6:0]  lights_valid;

   answer_type pending_answers[$];
   int         fail_count = 0;
   bit         calm = 0;      // no idling on either side while set
   int         beat_number = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint unsigned square_of(input coord_type a, input coord_type b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);   // |d| < 2**25, never saturates
   endfunction

   // update the table for a write, or push the answers a query will give
   task automatic light_table_answer(input light_beat_type b);
      int n, cap, hits;
      longint unsigned best, d2, c2;
      bit found;
      int best_i;
      answer_type a;
      n = (lights_valid > 64) ? 64 : lights_valid;
      case (b.op)
         OP_WR_BOX: begin
            tbl_lo_x[b.light_index] = b.lo_x; tbl_lo_y[b.light_index] = b.lo_y;
            tbl_lo_z[b.light_index] = b.lo_z; tbl_hi_x[b.light_index] = b.hi_x;
            tbl_hi_y[b.light_index] = b.hi_y; tbl_hi_z[b.light_index] = b.hi_z;
         end
         OP_WR_ORG: begin
            tbl_org_x[b.light_index] = b.lo_x; tbl_org_y[b.light_index] = b.lo_y;
            tbl_org_z[b.light_index] = b.lo_z;
            tbl_cutoff[b.light_index] = b.cutoff_dist;
            tbl_directional[b.light_index] = b.is_directional;
         end
         OP_GATHER: begin
            cap = (b.max_count > 64) ? 64 : b.max_count;
            hits = 0;
            for (int i = 0; i < n && hits < cap; i++) begin
               if (tbl_lo_x[i] > b.hi_x || tbl_lo_y[i] > b.hi_y || tbl_lo_z[i] > b.hi_z ||
                   tbl_hi_x[i] < b.lo_x || tbl_hi_y[i] < b.lo_y || tbl_hi_z[i] < b.lo_z)
                  continue;
               a.hit = 1'b1; a.result_index = i[5:0]; a.last = 1'b0;
               pending_answers.push_back(a);
               hits++;
            end
            if (hits == 0) begin
               a.hit = 1'b0; a.result_index = '0; a.last = 1'b1;
               pending_answers.push_back(a);
            end else
               pending_answers[$].last = 1'b1;
         end
         default: begin
            best = BOUND_SQ;
            found = 0;
            best_i = 0;
            for (int i = 0; i < n; i++) begin
               if (tbl_directional[i]) continue;
               d2 = square_of(b.lo_x, tbl_org_x[i]) + square_of(b.lo_y, tbl_org_y[i]) +
                    square_of(b.lo_z, tbl_org_z[i]);
               c2 = longint'(tbl_cutoff[i]) * longint'(tbl_cutoff[i]);
               if (d2 < best && d2 <= c2) begin
                  best = d2; best_i = i; found = 1;
               end
            end
            a.hit = found; a.result_index = found ? best_i[5:0] : 6'd0; a.last = 1'b1;
            pending_answers.push_back(a);
         end
      endcase
   endtask

   // result side: random stall, compare each beat with the oldest answer
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 0;
      else
         rsp_stall <= !calm && ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("result beat with nothing pending", 1, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_result_index !== want.result_index)
               report_mismatch("result_index", rsp_result_index, want.result_index);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // send one beat; valid stays high into the next beat unless we idle
   task automatic send_beat(input light_beat_type b, input bit typed, input answer_type a);
      if (!calm && $urandom_range(99) < 21) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_op <= b.op; req_light_index <= b.light_index;
      req_lo_x <= b.lo_x; req_lo_y <= b.lo_y; req_lo_z <= b.lo_z;
      req_hi_x <= b.hi_x; req_hi_y <= b.hi_y; req_hi_z <= b.hi_z;
      req_cutoff_dist <= b.cutoff_dist; req_is_directional <= b.is_directional;
      req_max_count <= b.max_count;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      if (typed) pending_answers.push_back(a);
      else light_table_answer(b);
      beat_number++;
   endtask

   // drain, let the walk settle, then write light_count
   task automatic write_light_count(input logic [6:0] v);
      req_valid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      lights_valid = v;
   endtask

   function automatic coord_type random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return coord_type'($urandom_range(400) - 200);
      if (pick < 80) return coord_type'($urandom);
      return pick[0] ? 24'sh7FFFFF : 24'sh800000;
   endfunction

   function automatic light_beat_type random_beat(input int force_op);
      light_beat_type b;
      int pick;
      pick = $urandom_range(99);
      if (force_op >= 0) b.op = op_type'(force_op);
      else if (pick < 20) b.op = OP_WR_BOX;
      else if (pick < 40) b.op = OP_WR_ORG;
      else if (pick < 75) b.op = OP_GATHER;
      else b.op = OP_NEAREST;
      b.light_index = 6'($urandom);
      b.lo_x = random_coord(); b.lo_y = random_coord(); b.lo_z = random_coord();
      if ($urandom_range(3) == 0) begin
         b.hi_x = coord_type'($urandom);
         b.hi_y = coord_type'($urandom);
         b.hi_z = coord_type'($urandom);
      end else begin
         // mostly well-formed boxes so gathers find something
         b.hi_x = b.lo_x + coord_type'($urandom_range(300));
         b.hi_y = b.lo_y + coord_type'($urandom_range(300));
         b.hi_z = b.lo_z + coord_type'($urandom_range(300));
      end
      b.cutoff_dist = ($urandom_range(3) == 0) ? 23'($urandom) : 23'($urandom_range(500));
      b.is_directional = ($urandom_range(3) == 0);
      b.max_count = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(70));
      return b;
   endfunction

   function automatic table_row_type row_beat(input op_type op, input int idx,
                                              input coord_type lo, input coord_type hi,
                                              input int cut, input bit dir, input int maxc,
                                              input bit typed, input bit hit, input int tidx);
      table_row_type r;
      r.is_csr = 0; r.csr_value = '0;
      r.beat.op = op; r.beat.light_index = 6'(idx);
      r.beat.lo_x = lo; r.beat.lo_y = lo; r.beat.lo_z = lo;
      r.beat.hi_x = hi; r.beat.hi_y = hi; r.beat.hi_z = hi;
      r.beat.cutoff_dist = 23'(cut); r.beat.is_directional = dir;
      r.beat.max_count = 7'(maxc);
      r.typed_answer = typed; r.typed_hit = hit; r.typed_index = 6'(tidx);
      return r;
   endfunction

   function automatic table_row_type row_csr(input int v);
      table_row_type r;
      r = row_beat(OP_WR_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      r.is_csr = 1; r.csr_value = 7'(v);
      return r;
   endfunction

   localparam coord_type CMIN = 24'sh800000;
   localparam coord_type CMAX = 24'sh7FFFFF;

   table_row_type directed[$];

   initial begin
      answer_type a;
      light_beat_type b;
      logic [6:0] phase_counts[6];
      reset = 1;
      csr_we <= 0; csr_wdata <= 0; req_valid <= 0; rsp_stall <= 0;
      req_op <= 0; req_light_index <= 0;
      req_lo_x <= 0; req_lo_y <= 0; req_lo_z <= 0;
      req_hi_x <= 0; req_hi_y <= 0; req_hi_z <= 0;
      req_cutoff_dist <= 0; req_is_directional <= 0; req_max_count <= 0;
      lights_valid = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty table: both queries miss
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMAX, 0, 0, 64, 1, 0, 0));
      directed.push_back(row_beat(OP_NEAREST, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      // four lights: full span, point at zero, small box, top corner
      directed.push_back(row_beat(OP_WR_BOX, 0, CMIN, CMAX, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_BOX, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_BOX, 2, 100, 200, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_BOX, 3, CMAX, CMAX, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_ORG, 0, 0, 0, 23'h7FFFFF, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_ORG, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_ORG, 2, 150, 0, 50, 1, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_WR_ORG, 3, CMIN, 0, 23'h7FFFFF, 0, 0, 0, 0, 0));
      directed.push_back(row_csr(4));
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMAX, 0, 0, 64, 0, 0, 0));
      // max_count zero gives the empty answer
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMAX, 0, 0, 0, 1, 0, 0));
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMAX, 0, 0, 127, 0, 0, 0));
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMAX, 0, 0, 1, 1, 1, 0));
      directed.push_back(row_beat(OP_GATHER, 0, CMIN, CMIN, 0, 0, 64, 0, 0, 0));
      directed.push_back(row_beat(OP_GATHER, 0, CMAX, CMAX, 0, 0, 64, 0, 0, 0));
      // tie at distance zero: first light wins
      directed.push_back(row_beat(OP_NEAREST, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      directed.push_back(row_beat(OP_NEAREST, 0, 150, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_NEAREST, 0, CMAX, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row_beat(OP_NEAREST, 0, CMIN, 0, 0, 0, 0, 0, 0, 0));

      foreach (directed[i]) begin
         if (directed[i].is_csr)
            write_light_count(directed[i].csr_value);
         else begin
            a.hit = directed[i].typed_hit;
            a.result_index = directed[i].typed_index;
            a.last = 1'b1;
            send_beat(directed[i].beat, directed[i].typed_answer, a);
         end
      end

      // fill every entry so any light_count is legal from here on
      for (int i = 0; i < 64; i++) begin
         b = random_beat(OP_WR_BOX); b.light_index = 6'(i); send_beat(b, 0, a);
         b = random_beat(OP_WR_ORG); b.light_index = 6'(i); send_beat(b, 0, a);
      end

      phase_counts = '{7'd64, 7'd127, 7'd1, 7'd63, 7'd0, 7'($urandom_range(2, 62))};
      for (int p = 0; p < 6; p++) begin
         write_light_count(phase_counts[p]);
         for (int k = 0; k < 36; k++) begin
            calm = (p == 2 || (p == 3 && k < 18));
            send_beat(random_beat(-1), 0, a);
         end
         calm = 0;
      end

      req_valid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("light_box_gather_and_nearest verification clean");
      else
         $display("light_box_gather_and_nearest verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("light_box_gather_and_nearest verification failed");
      $finish;
   end

endmodule

@@ files.f @@
src/lbg_pkg.sv
src/lbg_cell.sv
src/lbg_eval.sv
src/light_box_gather_and_nearest.sv
test/tb_light_box_gather_and_nearest.sv
